[sv/hermite_variable_rate_resampler_macros.svh]
// assertion macros for the resampler
`ifndef HERMITE_VARIABLE_RATE_RESAMPLER_MACROS_SVH
`define HERMITE_VARIABLE_RATE_RESAMPLER_MACROS_SVH
`ifndef SYNTHESIS
`define HVR_ASSERT(lbl, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
    else $error("resampler invariant violated");
`define HVR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("resampler sequencing violated");
`else
`define HVR_ASSERT(lbl, expr)
`define HVR_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[sv/hvr_pkg.sv]
`timescale 1ns / 1ps
package hvr_pkg;

  typedef enum logic [1:0] {
    REQ_PUSH   = 2'd0,
    REQ_OUTPUT = 2'd1,
    REQ_FADE   = 2'd2,
    REQ_SNAP   = 2'd3
  } req_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_CONS,
    ST_SLEW1,
    ST_SLEW2,
    ST_SLEW3,
    ST_READ,
    ST_H1,
    ST_H2,
    ST_H3,
    ST_H4,
    ST_H5,
    ST_H6,
    ST_FADE,
    ST_FMUL,
    ST_FLOAD,
    ST_FDIV,
    ST_FFIN,
    ST_OUT
  } hvr_state_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 23;

  localparam logic [CFG_IDX_W-1:0] REG_TARGET_RATIO = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_MIN_SLEW     = 1'b1;

  localparam logic [22:0] RATIO_MIN   = 23'd7;
  localparam logic [22:0] RATIO_MAX   = 23'd4194304;
  localparam logic [22:0] RATIO_RESET = 23'd65536;
  localparam logic [16:0] SLEW_RESET  = 17'd66;
  // ceil(2^26 / 5), exact for operands below 2^24
  localparam logic [23:0] RECIP5      = 24'd13421773;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [23:0] left_in;
    logic signed [23:0] right_in;
  } in_item_t;

  typedef struct packed {
    logic signed [23:0] left_out;
    logic signed [23:0] right_out;
    logic               underrun;
  } out_item_t;

endpackage

[sv/hermite_variable_rate_resampler.sv]
// push, arm fade and snap ratio beats keep ST_IDLE; the next beat is taken right after
// an output request runs consume, slew, read and Hermite states before out_valid rises
// on underrun ST_SLEW1 jumps to ST_FADE; a fade adds the multiply by 1/FADE_LENGTH
// the four taps are read one per cycle from the sample ring
// rst_n is synchronous; control state clears, ring contents stay undefined until written
`timescale 1ns / 1ps
`include "hermite_variable_rate_resampler_macros.svh"
module hermite_variable_rate_resampler #(
  parameter int RING_DEPTH  = 1024,
  parameter int FADE_LENGTH = 256
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hvr_pkg::in_item_t                   in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output hvr_pkg::out_item_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [hvr_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [hvr_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import hvr_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int CW    = $clog2(RING_DEPTH + 1);
  localparam int POSW  = AW + 16;
  localparam int SUMW  = ((POSW > 23) ? POSW : 23) + 1;
  localparam int FDW   = $clog2(FADE_LENGTH + 1);
  localparam int FPW   = 24 + FDW;
  localparam int FHW   = (FPW + 1) / 2;
  localparam int FK    = 23 + 2 * FDW;
  localparam int MW    = FK - FDW + 2;
  localparam int FQW   = FPW + MW + 1;

  localparam logic [POSW-1:0] MAXPOS   = POSW'(RING_DEPTH - 1) << 16;
  localparam logic [POSW-1:0] ONE_POS  = POSW'(1) << 16;
  localparam logic [POSW-1:0] POS_INIT = POSW'(2) << 16;
  // ceil(2^FK / FADE_LENGTH)
  localparam logic [MW-1:0]   FRECIP   =
    MW'(((64'd1 << FK) + 64'(FADE_LENGTH) - 64'd1) / 64'(FADE_LENGTH));

  hvr_state_t state_r, state_nxt;

  logic [47:0] ring [RING_DEPTH];
  logic [47:0] mem_q_r;
  logic [AW-1:0] rd_addr;
  logic          mem_we;

  logic [AW-1:0]   wr_idx_r;
  logic [CW-1:0]   count_r;
  logic [POSW-1:0] pos_r;
  logic [22:0]     smooth_r;
  logic [22:0]     target_r;
  logic [16:0]     minstep_r;
  logic [FDW-1:0]  fade_r;

  logic        dn_r;
  logic [22:0] mag_r;
  logic [48:0] sprod_r;
  logic [AW-1:0] i_r;
  logic [15:0]   t_r;
  logic [2:0]    rd_cnt_r;
  logic [47:0]   w_r [4];

  logic signed [29:0] a_r [2];
  logic signed [29:0] b_r [2];
  logic signed [29:0] c_r [2];
  logic signed [46:0] at_r [2];
  logic signed [48:0] m1_r [2];
  logic [31:0]        m2_r [2];
  logic signed [49:0] u_r [2];
  logic signed [50:0] n1_r [2];
  logic [31:0]        n2_r [2];
  logic signed [23:0] y_r [2];
  logic               und_r;

  logic signed [FPW:0]      fp_r [2];
  logic                     fneg_r [2];
  logic [FPW-1:0]           fabs_r [2];
  logic [FHW+MW-1:0]        plo_r [2];
  logic [FPW-FHW+MW-1:0]    phi_r [2];

  logic      out_valid_r;
  out_item_t out_r;

  logic signed [16:0] ts;
  assign ts = $signed({1'b0, t_r});

  // control
  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    mem_we    = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (in_data.req_type == REQ_PUSH) begin
            mem_we = 1'b1;
          end else if (in_data.req_type == REQ_OUTPUT) begin
            state_nxt = ST_CONS;
          end
        end
      end
      ST_CONS:  state_nxt = ST_SLEW1;
      ST_SLEW1: state_nxt = (count_r < CW'(6)) ? ST_FADE : ST_SLEW2;
      ST_SLEW2: state_nxt = ST_SLEW3;
      ST_SLEW3: state_nxt = ST_READ;
      ST_READ:  state_nxt = (rd_cnt_r == 3'd4) ? ST_H1 : ST_READ;
      ST_H1:    state_nxt = ST_H2;
      ST_H2:    state_nxt = ST_H3;
      ST_H3:    state_nxt = ST_H4;
      ST_H4:    state_nxt = ST_H5;
      ST_H5:    state_nxt = ST_H6;
      ST_H6:    state_nxt = ST_FADE;
      ST_FADE:  state_nxt = (fade_r != '0) ? ST_FMUL : ST_OUT;
      ST_FMUL:  state_nxt = ST_FLOAD;
      ST_FLOAD: state_nxt = ST_FDIV;
      ST_FDIV:  state_nxt = ST_FFIN;
      ST_FFIN:  state_nxt = ST_OUT;
      ST_OUT:   state_nxt = out_valid_r ? ST_OUT : ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // tap address: clamp to stored pairs, offset from the oldest
  logic [AW:0] tk_u, tj, osum, oldest, asum;
  logic [AW:0] cnt_m1;
  always_comb begin
    cnt_m1 = (AW + 1)'(count_r) - (AW + 1)'(1);
    tk_u   = {1'b0, i_r} + (AW + 1)'(rd_cnt_r[1:0]);
    if (tk_u == '0) begin
      tj = '0;
    end else begin
      tj = tk_u - (AW + 1)'(1);
    end
    if (tj > cnt_m1) begin
      tj = cnt_m1;
    end
    osum = (AW + 1)'(wr_idx_r) + (AW + 1)'(RING_DEPTH) - (AW + 1)'(count_r);
    oldest = (osum >= (AW + 1)'(RING_DEPTH)) ? osum - (AW + 1)'(RING_DEPTH) : osum;
    asum = oldest + tj;
    if (asum >= (AW + 1)'(RING_DEPTH)) begin
      asum = asum - (AW + 1)'(RING_DEPTH);
    end
    rd_addr = asum[AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      ring[wr_idx_r] <= {in_data.left_in, in_data.right_in};
    end
    mem_q_r <= ring[rd_addr];
  end

  // consumption and slew
  logic [AW-1:0] pi;
  logic [CW-1:0] c_raw, c_lim, c_use;
  logic [26:0]   mag13;
  logic [22:0]   q5, step, mv;
  logic [SUMW-1:0] psum;
  always_comb begin
    pi    = pos_r[POSW-1:16];
    c_raw = (pi > AW'(2)) ? CW'(pi) - CW'(2) : '0;
    c_lim = (count_r > CW'(7)) ? count_r - CW'(7) : '0;
    c_use = (c_raw > c_lim) ? c_lim : c_raw;
    mag13 = ({4'b0, mag_r} << 3) + ({4'b0, mag_r} << 2) + {4'b0, mag_r};
    q5    = sprod_r[48:26];
    step  = (q5 < {6'b0, minstep_r}) ? {6'b0, minstep_r} : q5;
    mv    = (mag_r < step) ? mag_r : step;
    psum  = SUMW'(pos_r) + SUMW'(smooth_r);
  end

  // interpolation arithmetic
  logic signed [29:0] e0 [2], e1 [2], e2 [2], e3 [2], d12 [2];
  logic signed [30:0] hi [2];
  logic signed [31:0] bh [2];
  logic signed [33:0] uh [2];
  logic signed [51:0] vv [2], ss [2], rr [2];
  logic signed [23:0] ysat [2];
  logic [FPW-1:0]     fabs [2];
  logic [FQW-1:0]     fsum [2];
  logic [23:0]        fq [2];
  always_comb begin
    for (int ch = 0; ch < 2; ch++) begin
      e0[ch] = 30'($signed(w_r[0][47-24*ch -: 24]));
      e1[ch] = 30'($signed(w_r[1][47-24*ch -: 24]));
      e2[ch] = 30'($signed(w_r[2][47-24*ch -: 24]));
      e3[ch] = 30'($signed(w_r[3][47-24*ch -: 24]));
      d12[ch] = e1[ch] - e2[ch];
      hi[ch] = at_r[ch][46:16];
      bh[ch] = 32'(b_r[ch]) + 32'(hi[ch]);
      uh[ch] = u_r[ch][49:16];
      vv[ch] = 52'(n1_r[ch]) + 52'($signed({1'b0, n2_r[ch][31:16]}));
      ss[ch] = (vv[ch] + 52'sd65536) >>> 17;
      rr[ch] = 52'(e1[ch]) + ss[ch];
      if (rr[ch] > 52'sd8388607) begin
        ysat[ch] = 24'sh7fffff;
      end else if (rr[ch] < -52'sd8388608) begin
        ysat[ch] = 24'sh800000;
      end else begin
        ysat[ch] = rr[ch][23:0];
      end
      fabs[ch] = fp_r[ch][FPW] ? FPW'(-fp_r[ch]) : FPW'(fp_r[ch]);
      fsum[ch] = (FQW'(phi_r[ch]) << FHW) + FQW'(plo_r[ch]);
      fq[ch]   = fsum[ch][FK +: 24];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_idx_r    <= '0;
      count_r     <= '0;
      pos_r       <= POS_INIT;
      smooth_r    <= RATIO_RESET;
      target_r    <= RATIO_RESET;
      minstep_r   <= SLEW_RESET;
      fade_r      <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        if (cfg_index == REG_TARGET_RATIO) begin
          if (cfg_data < RATIO_MIN) begin
            target_r <= RATIO_MIN;
          end else if (cfg_data > RATIO_MAX) begin
            target_r <= RATIO_MAX;
          end else begin
            target_r <= cfg_data;
          end
        end else if (cfg_index == REG_MIN_SLEW) begin
          minstep_r <= cfg_data[16:0];
        end
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            case (in_data.req_type)
              REQ_PUSH: begin
                wr_idx_r <= (wr_idx_r == AW'(RING_DEPTH - 1)) ? '0 : wr_idx_r + AW'(1);
                if (count_r < CW'(RING_DEPTH)) begin
                  count_r <= count_r + CW'(1);
                end else begin
                  pos_r <= (pos_r >= ONE_POS) ? pos_r - ONE_POS : '0;
                end
              end
              REQ_FADE: fade_r   <= FDW'(FADE_LENGTH);
              REQ_SNAP: smooth_r <= target_r;
              default: ;
            endcase
          end
        end
        ST_CONS: begin
          if (c_use != '0) begin
            count_r <= count_r - c_use;
            pos_r   <= pos_r - (POSW'(c_use) << 16);
          end
        end
        ST_SLEW3: begin
          smooth_r <= dn_r ? smooth_r - mv : smooth_r + mv;
          rd_cnt_r <= '0;
        end
        ST_READ: begin
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == 3'd0) begin
            pos_r <= (psum > SUMW'(MAXPOS)) ? MAXPOS : psum[POSW-1:0];
          end
        end
        ST_FFIN:  fade_r  <= fade_r - FDW'(1);
        ST_OUT: begin
          if (!out_valid_r) begin
            out_valid_r <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    case (state_r)
      ST_SLEW1: begin
        und_r <= (count_r < CW'(6));
        y_r[0] <= '0;
        y_r[1] <= '0;
        dn_r  <= (target_r < smooth_r);
        mag_r <= (target_r < smooth_r) ? smooth_r - target_r : target_r - smooth_r;
      end
      ST_SLEW2: begin
        sprod_r <= 49'(mag13[26:2]) * 49'(RECIP5);
      end
      ST_SLEW3: begin
        i_r <= pos_r[POSW-1:16];
        t_r <= pos_r[15:0];
      end
      ST_READ: begin
        if (rd_cnt_r != 3'd0) begin
          w_r[0] <= w_r[1];
          w_r[1] <= w_r[2];
          w_r[2] <= w_r[3];
          w_r[3] <= mem_q_r;
        end
      end
      default: ;
    endcase
    for (int ch = 0; ch < 2; ch++) begin
      case (state_r)
        ST_H1: begin
          a_r[ch] <= (d12[ch] <<< 1) + d12[ch] + e3[ch] - e0[ch];
          b_r[ch] <= (e0[ch] <<< 1) - ((e1[ch] <<< 2) + e1[ch]) + (e2[ch] <<< 2) - e3[ch];
          c_r[ch] <= e2[ch] - e0[ch];
        end
        ST_H2: at_r[ch] <= 47'(a_r[ch]) * 47'(ts);
        ST_H3: begin
          m1_r[ch] <= 49'(bh[ch]) * 49'(ts);
          m2_r[ch] <= 32'(at_r[ch][15:0]) * 32'(t_r);
        end
        ST_H4: begin
          u_r[ch] <= 50'(m1_r[ch]) + 50'($signed({1'b0, m2_r[ch][31:16]}))
                     + (50'(c_r[ch]) <<< 16);
        end
        ST_H5: begin
          n1_r[ch] <= 51'(uh[ch]) * 51'(ts);
          n2_r[ch] <= 32'(u_r[ch][15:0]) * 32'(t_r);
        end
        ST_H6: y_r[ch] <= ysat[ch];
        ST_FMUL: fp_r[ch] <= (FPW + 1)'(y_r[ch]) * (FPW + 1)'($signed({1'b0, fade_r}));
        ST_FLOAD: begin
          fneg_r[ch] <= fp_r[ch][FPW];
          fabs_r[ch] <= fabs[ch];
        end
        ST_FDIV: begin
          plo_r[ch] <= (FHW + MW)'(fabs_r[ch][FHW-1:0]) * (FHW + MW)'(FRECIP);
          phi_r[ch] <= (FPW - FHW + MW)'(fabs_r[ch][FPW-1:FHW]) * (FPW - FHW + MW)'(FRECIP);
        end
        ST_FFIN: y_r[ch] <= fneg_r[ch] ? -$signed(fq[ch]) : $signed(fq[ch]);
        default: ;
      endcase
    end
    if (state_r == ST_OUT && !out_valid_r) begin
      out_r.left_out  <= y_r[0];
      out_r.right_out <= y_r[1];
      out_r.underrun  <= und_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign cfg_ready = 1'b1;

  `HVR_ASSERT(a_count_bound, count_r <= CW'(RING_DEPTH))
  `HVR_ASSERT(a_pos_bound, pos_r <= MAXPOS)
  `HVR_ASSERT(a_ratio_bound, smooth_r >= RATIO_MIN && smooth_r <= RATIO_MAX)
  `HVR_ASSERT_NEXT(a_out_load, state_r == ST_OUT && !out_valid_r, out_valid_r)

endmodule
